@@ sv/dcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_pkg: shared constants for the distance constraint relaxation block
// Holds the bounce select limits and the damping divisor table.
// ----------------------------------------------------------------------------
package dcr_pkg;

    localparam int BSEL_W = 4;
    localparam int POW3_W = 15;
    localparam logic [BSEL_W-1:0] BOUNCE_MAX = 4'd10;

    // Damping divisor 3^b; the top setting means no motion and reads as zero
    function automatic logic [POW3_W-1:0] pow3(input logic [BSEL_W-1:0] b);
        logic [POW3_W-1:0] v;
        case (b)
            4'd0: v = 15'd1;
            4'd1: v = 15'd3;
            4'd2: v = 15'd9;
            4'd3: v = 15'd27;
            4'd4: v = 15'd81;
            4'd5: v = 15'd243;
            4'd6: v = 15'd729;
            4'd7: v = 15'd2187;
            4'd8: v = 15'd6561;
            4'd9: v = 15'd19683;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ sv/dcr_sqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_sqrt: pipelined integer square root
// One result bit per stage, floor of the root, with a side word carried along.
// ----------------------------------------------------------------------------
module dcr_sqrt #(
    parameter int RW     = 25,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2*RW-1:0]   i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [RW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int SW = 2 * RW;

    logic              r_v    [RW];
    logic [SW-1:0]     r_rem  [RW];
    logic [SW-1:0]     r_res  [RW];
    logic [SIDE_W-1:0] r_side [RW];

    logic              cur_v    [RW];
    logic [SW-1:0]     cur_rem  [RW];
    logic [SW-1:0]     cur_res  [RW];
    logic [SIDE_W-1:0] cur_side [RW];
    logic [SW-1:0]     n_rem    [RW];
    logic [SW-1:0]     n_res    [RW];
    logic              adv      [RW];

    // Select each stage's source: the input port or the stage before
    always_comb begin
        cur_v[0]    = i_valid;
        cur_rem[0]  = i_rad;
        cur_res[0]  = '0;
        cur_side[0] = i_side;
        for (int k = 1; k < RW; k++) begin
            cur_v[k]    = r_v[k-1];
            cur_rem[k]  = r_rem[k-1];
            cur_res[k]  = r_res[k-1];
            cur_side[k] = r_side[k-1];
        end
    end

    // Resolve one root bit per stage
    always_comb begin
        logic [SW-1:0] one;
        logic [SW-1:0] trial;
        for (int k = 0; k < RW; k++) begin
            one   = {{(SW-1){1'b0}}, 1'b1} << (SW - 2 - 2 * k);
            trial = cur_res[k] + one;
            if (cur_rem[k] >= trial) begin
                n_rem[k] = cur_rem[k] - trial;
                n_res[k] = (cur_res[k] >> 1) + one;
            end else begin
                n_rem[k] = cur_rem[k];
                n_res[k] = cur_res[k] >> 1;
            end
        end
    end

    // A stage advances when empty or when the one after it advances
    always_comb begin
        adv[RW-1] = !r_v[RW-1] || i_ready;
        for (int k = RW - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < RW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < RW; k++) begin
                if (adv[k]) begin
                    r_v[k] <= cur_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < RW; k++) begin
            if (adv[k]) begin
                r_rem[k]  <= n_rem[k];
                r_res[k]  <= n_res[k];
                r_side[k] <= cur_side[k];
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[RW-1];
    assign o_root  = r_res[RW-1][RW-1:0];
    assign o_side  = r_side[RW-1];

endmodule

@@ sv/dcr_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcr_div: pipelined restoring divider, two dividends over one divisor
// One quotient bit per stage; the quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module dcr_div #(
    parameter int NW     = 50,
    parameter int DW     = 41,
    parameter int QW     = 25,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [NW-1:0]     i_num_x,
    input  logic [NW-1:0]     i_num_y,
    input  logic [DW-1:0]     i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [QW-1:0]     o_quo_x,
    output logic [QW-1:0]     o_quo_y,
    output logic [SIDE_W-1:0] o_side
);

    localparam int TW = DW + QW;

    logic              r_v    [QW];
    logic [NW-1:0]     r_rx   [QW];
    logic [NW-1:0]     r_ry   [QW];
    logic [QW-1:0]     r_qx   [QW];
    logic [QW-1:0]     r_qy   [QW];
    logic [DW-1:0]     r_den  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    logic              cur_v    [QW];
    logic [NW-1:0]     cur_rx   [QW];
    logic [NW-1:0]     cur_ry   [QW];
    logic [QW-1:0]     cur_qx   [QW];
    logic [QW-1:0]     cur_qy   [QW];
    logic [DW-1:0]     cur_den  [QW];
    logic [SIDE_W-1:0] cur_side [QW];
    logic [NW-1:0]     n_rx     [QW];
    logic [NW-1:0]     n_ry     [QW];
    logic [QW-1:0]     n_qx     [QW];
    logic [QW-1:0]     n_qy     [QW];
    logic              adv      [QW];

    // Select each stage's source: the input port or the stage before
    always_comb begin
        cur_v[0]    = i_valid;
        cur_rx[0]   = i_num_x;
        cur_ry[0]   = i_num_y;
        cur_qx[0]   = '0;
        cur_qy[0]   = '0;
        cur_den[0]  = i_den;
        cur_side[0] = i_side;
        for (int k = 1; k < QW; k++) begin
            cur_v[k]    = r_v[k-1];
            cur_rx[k]   = r_rx[k-1];
            cur_ry[k]   = r_ry[k-1];
            cur_qx[k]   = r_qx[k-1];
            cur_qy[k]   = r_qy[k-1];
            cur_den[k]  = r_den[k-1];
            cur_side[k] = r_side[k-1];
        end
    end

    // Try the shifted divisor against each remainder, most significant bit first
    always_comb begin
        logic [TW-1:0] trial;
        logic [TW-1:0] ext_x;
        logic [TW-1:0] ext_y;
        logic [TW-1:0] dif_x;
        logic [TW-1:0] dif_y;
        for (int k = 0; k < QW; k++) begin
            trial = TW'(cur_den[k]) << (QW - 1 - k);
            ext_x = TW'(cur_rx[k]);
            ext_y = TW'(cur_ry[k]);
            dif_x = ext_x - trial;
            dif_y = ext_y - trial;
            if (ext_x >= trial) begin
                n_rx[k] = dif_x[NW-1:0];
                n_qx[k] = {cur_qx[k][QW-2:0], 1'b1};
            end else begin
                n_rx[k] = cur_rx[k];
                n_qx[k] = {cur_qx[k][QW-2:0], 1'b0};
            end
            if (ext_y >= trial) begin
                n_ry[k] = dif_y[NW-1:0];
                n_qy[k] = {cur_qy[k][QW-2:0], 1'b1};
            end else begin
                n_ry[k] = cur_ry[k];
                n_qy[k] = {cur_qy[k][QW-2:0], 1'b0};
            end
        end
    end

    // A stage advances when empty or when the one after it advances
    always_comb begin
        adv[QW-1] = !r_v[QW-1] || i_ready;
        for (int k = QW - 2; k >= 0; k--) begin
            adv[k] = !r_v[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < QW; k++) begin
                r_v[k] <= 1'b0;
            end
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (adv[k]) begin
                    r_v[k] <= cur_v[k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (adv[k]) begin
                r_rx[k]   <= n_rx[k];
                r_ry[k]   <= n_ry[k];
                r_qx[k]   <= n_qx[k];
                r_qy[k]   <= n_qy[k];
                r_den[k]  <= cur_den[k];
                r_side[k] <= cur_side[k];
            end
        end
    end

    assign o_ready = adv[0];
    assign o_valid = r_v[QW-1];
    assign o_quo_x = r_qx[QW-1];
    assign o_quo_y = r_qy[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

@@ sv/distance_constraint_relax.sv @@
`timescale 1ns / 1ps
// Pipeline: stages A to D, the square root with one root bit per stage, stages E to G,
// the divider with one quotient bit per stage, then stages H and I.
// Throughput: one request per cycle; every stage holds its own valid bit and a stalled
// output only backs up the stages that are full.
// Reset: synchronous active-low reset empties every stage; payload registers are not reset.
// ----------------------------------------------------------------------------
// distance_constraint_relax: one relaxation step of a two-point stick
// Computes the stick length, its error against the rest length, and moves
// each unpinned endpoint half the error along the stick, damped by 3^-b.
// ----------------------------------------------------------------------------
module distance_constraint_relax
    import dcr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // a_x, a_y, b_x, b_y, rest_length, bounce_tenths, zero fill
    input  logic [((5*COORD_WIDTH+3+7)/8)*8-1:0] s_axis_tdata,
    // a_fixed, b_fixed
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // new_a_x, new_a_y, new_b_x, new_b_y, zero fill
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // coincident
    output logic [0:0] m_axis_tuser
);

    localparam int CW    = COORD_WIDTH;
    localparam int ODW   = ((4*CW+7)/8)*8;
    localparam int MW    = CW + 1;
    localparam int SQW   = 2 * MW;
    localparam int RW    = CW + 1;
    localparam int ESW   = CW + 2;
    localparam int EW    = CW + 1;
    localparam int TLW   = CW + 2;
    localparam int DENW  = TLW + POW3_W;
    localparam int NW    = MW + EW;
    localparam int QW    = CW + 1;
    localparam int OW    = CW + 2;
    localparam int SUMW  = CW + 3;

    typedef struct packed {
        logic [CW-1:0]     ax;
        logic [CW-1:0]     ay;
        logic [CW-1:0]     bx;
        logic [CW-1:0]     by;
        logic              af;
        logic              bf;
        logic [CW-2:0]     rest;
        logic [BSEL_W-1:0] bsel;
        logic              coin;
        logic              dxneg;
        logic              dyneg;
        logic [MW-1:0]     mdx;
        logic [MW-1:0]     mdy;
    } t_front;

    typedef struct packed {
        logic [CW-1:0] ax;
        logic [CW-1:0] ay;
        logic [CW-1:0] bx;
        logic [CW-1:0] by;
        logic          af;
        logic          bf;
        logic          coin;
        logic          zero;
        logic          sx;
        logic          sy;
    } t_back;

    // Clamp a widened sum to the signed coordinate range
    function automatic logic [CW-1:0] sat(input logic [SUMW-1:0] v);
        logic [CW-1:0] r;
        if (!v[SUMW-1] && (v[SUMW-2:CW-1] != '0)) begin
            r = {1'b0, {(CW-1){1'b1}}};
        end else if (v[SUMW-1] && (v[SUMW-2:CW-1] != '1)) begin
            r = {1'b1, {(CW-1){1'b0}}};
        end else begin
            r = v[CW-1:0];
        end
        return r;
    endfunction

    // Stage valid bits
    logic r_va, r_vb, r_vc, r_vd, r_ve, r_vf, r_vg, r_vh, r_vi;
    logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f, adv_g, adv_h, adv_i;

    // Payload registers
    t_front          r_fa, r_fb, r_fc, r_fd, r_fe, r_ff;
    t_back           r_bf, r_bg, r_bh;
    logic [CW:0]     r_dx, r_dy;
    logic [SQW-1:0]  r_sqx, r_sqy, r_rad;
    logic [ESW-1:0]  r_err;
    logic [TLW-1:0]  r_twol, r_twol_f;
    logic [EW-1:0]   r_merr;
    logic [POW3_W-1:0] r_p3;
    logic [NW-1:0]   r_px, r_py;
    logic [DENW-1:0] r_den;
    logic [OW-1:0]   r_ox, r_oy;
    logic [CW-1:0]   r_nax, r_nay, r_nbx, r_nby;
    logic            r_coin;

    // Next values
    t_front          n_fa, n_fb;
    t_back           n_bf;
    logic [CW:0]     n_dx, n_dy;
    logic [SQW-1:0]  n_sqx, n_sqy;
    logic [ESW-1:0]  n_err;
    logic [EW-1:0]   n_merr;
    logic [ESW-1:0]  neg_err;
    logic [NW-1:0]   n_px, n_py;
    logic [DENW-1:0] n_den;
    logic [OW-1:0]   n_ox, n_oy;
    logic [SUMW-1:0] sum_ax, sum_ay, sum_bx, sum_by;

    // Square root and divider links
    logic            sq_ready, sq_valid;
    logic [RW-1:0]   sq_root;
    t_front          sq_side;
    logic            dv_ready, dv_valid;
    logic [QW-1:0]   dv_qx, dv_qy;
    t_back           dv_side;

    // Ready chain, back to front
    assign adv_i = !r_vi || m_axis_tready;
    assign adv_h = !r_vh || adv_i;
    assign adv_g = !r_vg || dv_ready;
    assign adv_f = !r_vf || adv_g;
    assign adv_e = !r_ve || adv_f;
    assign adv_d = !r_vd || sq_ready;
    assign adv_c = !r_vc || adv_d;
    assign adv_b = !r_vb || adv_c;
    assign adv_a = !r_va || adv_b;
    assign s_axis_tready = adv_a;

    // Stage A: unpack the request, clamp the bounce select and take the differences
    always_comb begin
        n_fa       = '0;
        n_fa.ax    = s_axis_tdata[CW-1:0];
        n_fa.ay    = s_axis_tdata[2*CW-1:CW];
        n_fa.bx    = s_axis_tdata[3*CW-1:2*CW];
        n_fa.by    = s_axis_tdata[4*CW-1:3*CW];
        n_fa.rest  = s_axis_tdata[5*CW-2:4*CW];
        n_fa.bsel  = (s_axis_tdata[5*CW+2:5*CW-1] > BOUNCE_MAX) ?
                     BOUNCE_MAX : s_axis_tdata[5*CW+2:5*CW-1];
        n_fa.af    = s_axis_tuser[0];
        n_fa.bf    = s_axis_tuser[1];
        n_dx = {n_fa.bx[CW-1], n_fa.bx} - {n_fa.ax[CW-1], n_fa.ax};
        n_dy = {n_fa.by[CW-1], n_fa.by} - {n_fa.ay[CW-1], n_fa.ay};
    end

    // Stage B: magnitudes, signs and the coincidence flag
    always_comb begin
        n_fb       = r_fa;
        n_fb.dxneg = r_dx[CW];
        n_fb.dyneg = r_dy[CW];
        n_fb.mdx   = r_dx[CW] ? (~r_dx + 1'b1) : r_dx;
        n_fb.mdy   = r_dy[CW] ? (~r_dy + 1'b1) : r_dy;
        n_fb.coin  = (r_dx == '0) && (r_dy == '0);
    end

    // Stage C: squares
    always_comb begin
        n_sqx = SQW'(r_fb.mdx) * SQW'(r_fb.mdx);
        n_sqy = SQW'(r_fb.mdy) * SQW'(r_fb.mdy);
    end

    dcr_sqrt #(
        .RW     (RW),
        .SIDE_W ($bits(t_front))
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vd),
        .o_ready (sq_ready),
        .i_rad   (r_rad),
        .i_side  (r_fd),
        .o_valid (sq_valid),
        .i_ready (adv_e),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // Stage E: length error against the rest length
    assign n_err = {3'b000, sq_side.rest} - {1'b0, sq_root};

    // Stage F: error magnitude, offset signs and the no-motion flag
    always_comb begin
        neg_err   = ~r_err + 1'b1;
        n_merr    = r_err[ESW-1] ? neg_err[EW-1:0] : r_err[EW-1:0];
        n_bf.ax   = r_fe.ax;
        n_bf.ay   = r_fe.ay;
        n_bf.bx   = r_fe.bx;
        n_bf.by   = r_fe.by;
        n_bf.af   = r_fe.af;
        n_bf.bf   = r_fe.bf;
        n_bf.coin = r_fe.coin;
        n_bf.zero = r_fe.coin || (r_fe.bsel == BOUNCE_MAX);
        n_bf.sx   = r_fe.dxneg ^ r_err[ESW-1];
        n_bf.sy   = r_fe.dyneg ^ r_err[ESW-1];
    end

    // Stage G: dividends and the damped divisor
    always_comb begin
        n_px  = NW'(r_ff.mdx) * NW'(r_merr);
        n_py  = NW'(r_ff.mdy) * NW'(r_merr);
        n_den = DENW'(r_twol_f) * DENW'(r_p3);
    end

    dcr_div #(
        .NW     (NW),
        .DW     (DENW),
        .QW     (QW),
        .SIDE_W ($bits(t_back))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vg),
        .o_ready (dv_ready),
        .i_num_x (r_px),
        .i_num_y (r_py),
        .i_den   (r_den),
        .i_side  (r_bg),
        .o_valid (dv_valid),
        .i_ready (adv_h),
        .o_quo_x (dv_qx),
        .o_quo_y (dv_qy),
        .o_side  (dv_side)
    );

    // Stage H: signed offsets, dropped for coincident ends or full damping
    always_comb begin
        if (dv_side.zero) begin
            n_ox = '0;
            n_oy = '0;
        end else begin
            n_ox = dv_side.sx ? (~OW'(dv_qx) + 1'b1) : OW'(dv_qx);
            n_oy = dv_side.sy ? (~OW'(dv_qy) + 1'b1) : OW'(dv_qy);
        end
    end

    // Stage I: apply offsets to the free endpoints and saturate
    always_comb begin
        sum_bx = {{3{r_bh.bx[CW-1]}}, r_bh.bx} + {r_ox[OW-1], r_ox};
        sum_by = {{3{r_bh.by[CW-1]}}, r_bh.by} + {r_oy[OW-1], r_oy};
        sum_ax = {{3{r_bh.ax[CW-1]}}, r_bh.ax} - {r_ox[OW-1], r_ox};
        sum_ay = {{3{r_bh.ay[CW-1]}}, r_bh.ay} - {r_oy[OW-1], r_oy};
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
            r_vf <= 1'b0;
            r_vg <= 1'b0;
            r_vh <= 1'b0;
            r_vi <= 1'b0;
        end else begin
            if (adv_a) r_va <= s_axis_tvalid;
            if (adv_b) r_vb <= r_va;
            if (adv_c) r_vc <= r_vb;
            if (adv_d) r_vd <= r_vc;
            if (adv_e) r_ve <= sq_valid;
            if (adv_f) r_vf <= r_ve;
            if (adv_g) r_vg <= r_vf;
            if (adv_h) r_vh <= dv_valid;
            if (adv_i) r_vi <= r_vh;
        end
    end

    // Payload, held while a stage is blocked
    always_ff @(posedge i_clk) begin
        if (adv_a) begin
            r_fa <= n_fa;
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (adv_b) begin
            r_fb <= n_fb;
        end
        if (adv_c) begin
            r_fc  <= r_fb;
            r_sqx <= n_sqx;
            r_sqy <= n_sqy;
        end
        if (adv_d) begin
            r_fd  <= r_fc;
            r_rad <= r_sqx + r_sqy;
        end
        if (adv_e) begin
            r_fe   <= sq_side;
            r_err  <= n_err;
            r_twol <= {sq_root, 1'b0};
        end
        if (adv_f) begin
            r_ff     <= r_fe;
            r_bf     <= n_bf;
            r_merr   <= n_merr;
            r_twol_f <= r_twol;
            r_p3     <= pow3(r_fe.bsel);
        end
        if (adv_g) begin
            r_bg  <= r_bf;
            r_px  <= n_px;
            r_py  <= n_py;
            r_den <= n_den;
        end
        if (adv_h) begin
            r_bh <= dv_side;
            r_ox <= n_ox;
            r_oy <= n_oy;
        end
        if (adv_i) begin
            r_nax  <= r_bh.af ? r_bh.ax : sat(sum_ax);
            r_nay  <= r_bh.af ? r_bh.ay : sat(sum_ay);
            r_nbx  <= r_bh.bf ? r_bh.bx : sat(sum_bx);
            r_nby  <= r_bh.bf ? r_bh.by : sat(sum_by);
            r_coin <= r_bh.coin;
        end
    end

    assign m_axis_tvalid = r_vi;
    assign m_axis_tdata  = ODW'({r_nby, r_nbx, r_nay, r_nax});
    assign m_axis_tuser  = r_coin;

endmodule

@@ test/tb_distance_constraint_relax.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_distance_constraint_relax: self-checking bench for the stick relaxation
// Streams sticks through the block, predicts each corrected stick in the
// bench itself and compares every returned request field by field, with
// random idling on both sides and a drained pause in the middle of the run.
// ----------------------------------------------------------------------------
module tb_distance_constraint_relax
    import dcr_pkg::*;
();

    localparam int CW = 24;
    localparam int LATENCY = 2 * CW + 11;
    localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
    localparam longint CMIN = -CMAX - 1;

    typedef struct {
        logic signed [CW-1:0] a_x, a_y, b_x, b_y;
        logic                 a_fixed, b_fixed;
        logic [CW-2:0]        rest_length;
        logic [BSEL_W-1:0]    bounce_tenths;
    } t_stick;

    typedef struct {
        logic signed [CW-1:0] new_a_x, new_a_y, new_b_x, new_b_y;
        logic                 coincident;
    } t_moved;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // a_x, a_y, b_x, b_y, rest_length, bounce_tenths, fill
    logic [1:0]   s_axis_tuser = '0;   // a_fixed, b_fixed
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [95:0]  m_axis_tdata;        // new_a_x, new_a_y, new_b_x, new_b_y
    logic [0:0]   m_axis_tuser;        // coincident

    t_moved expected_moves[$];
    int     fail_count = 0;
    bit     idle_on = 1'b0;

    distance_constraint_relax #(.COORD_WIDTH(CW)) u_top (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Damping divisors 3^b, zero meaning no motion at all
    longint unsigned damp_div[0:10] = '{1, 3, 9, 27, 81, 243, 729, 2187, 6561, 19683, 0};

    function automatic longint clamp_coord(longint v);
        if (v > CMAX) return CMAX;
        if (v < CMIN) return CMIN;
        return v;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned r, c;
        r = 0;
        for (int k = 31; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= n) r = c;
        end
        return r;
    endfunction

    function automatic longint pull_offset(longint d, longint err, longint unsigned len,
                                           longint unsigned dv);
        longint unsigned q, md, me;
        if (dv == 0 || d == 0 || err == 0) return 0;
        md = (d < 0) ? -d : d;
        me = (err < 0) ? -err : err;
        q = (md * me) / (2 * len) / dv;
        return ((d < 0) != (err < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_moved relax_stick(t_stick s);
        t_moved m;
        longint ax, ay, bx, by, dx, dy, err, ox, oy;
        longint unsigned len, dv;
        ax = longint'(s.a_x); ay = longint'(s.a_y);
        bx = longint'(s.b_x); by = longint'(s.b_y);
        dx = bx - ax;
        dy = by - ay;
        m.coincident = (dx == 0 && dy == 0);
        if (!m.coincident) begin
            len = floor_sqrt(longint'(dx * dx) + longint'(dy * dy));
            err = longint'(s.rest_length) - longint'(len);
            dv = damp_div[(s.bounce_tenths > BOUNCE_MAX) ? 10 : s.bounce_tenths];
            ox = pull_offset(dx, err, len, dv);
            oy = pull_offset(dy, err, len, dv);
            if (!s.b_fixed) begin
                bx = clamp_coord(bx + ox);
                by = clamp_coord(by + oy);
            end
            if (!s.a_fixed) begin
                ax = clamp_coord(ax - ox);
                ay = clamp_coord(ay - oy);
            end
        end
        m.new_a_x = ax[CW-1:0];
        m.new_a_y = ay[CW-1:0];
        m.new_b_x = bx[CW-1:0];
        m.new_b_y = by[CW-1:0];
        return m;
    endfunction

    // Offer one stick, holding it until the block takes the request
    task automatic send_stick(t_stick s);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        s_axis_tdata = {5'b0, s.bounce_tenths, s.rest_length, s.b_y, s.b_x, s.a_y, s.a_x};
        s_axis_tuser = {s.b_fixed, s.a_fixed};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_moves.push_back(relax_stick(s));
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    function automatic t_stick make_stick(longint ax, longint ay, longint bx, longint by,
                                          bit af, bit bf, longint rest, int b);
        t_stick s;
        s.a_x = CW'(ax); s.a_y = CW'(ay); s.b_x = CW'(bx); s.b_y = CW'(by);
        s.a_fixed = af; s.b_fixed = bf;
        s.rest_length = (CW-1)'(rest); s.bounce_tenths = BSEL_W'(b);
        return s;
    endfunction

    // Mostly short sticks near their rest length, some anywhere in range
    function automatic t_stick random_stick();
        t_stick s;
        int span;
        s.a_x = CW'($urandom); s.a_y = CW'($urandom);
        s.b_x = CW'($urandom); s.b_y = CW'($urandom);
        s.a_fixed = 1'($urandom); s.b_fixed = 1'($urandom);
        s.rest_length = (CW-1)'($urandom);
        s.bounce_tenths = BSEL_W'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0) begin
            span = 1 << $urandom_range(0, 22);
            s.b_x = CW'(longint'(s.a_x) + longint'($urandom_range(0, 2 * span)) - span);
            s.b_y = CW'(longint'(s.a_y) + longint'($urandom_range(0, 2 * span)) - span);
            s.rest_length = (CW-1)'($urandom_range(0, 2 * span));
            if ($urandom_range(0, 30) == 0) s.b_x = s.a_x;
            if ($urandom_range(0, 30) == 0) begin
                s.b_x = s.a_x;
                s.b_y = s.a_y;
            end
        end
        if ($urandom_range(0, 3) == 0) s.bounce_tenths = BSEL_W'($urandom_range(0, 2));
        return s;
    endfunction

    // Throttle the result side in random bursts while idling is enabled
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (!idle_on) begin
                m_axis_tready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (m_axis_tready && $urandom_range(0, 5) == 0) begin
                m_axis_tready = 1'b0;
                hold = $urandom_range(1, 19) - 1;
            end else begin
                m_axis_tready = 1'b1;
                hold = $urandom_range(0, 12);
            end
        end
    end

    // Compare each returned request with the oldest prediction
    always @(posedge i_clk) begin
        t_moved e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_moves.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                fail_count++;
            end else begin
                e = expected_moves.pop_front();
                if (m_axis_tdata[23:0] !== e.new_a_x) begin
                    $error("new_a_x exp %0d got %0d", e.new_a_x, $signed(m_axis_tdata[23:0]));
                    fail_count++;
                end
                if (m_axis_tdata[47:24] !== e.new_a_y) begin
                    $error("new_a_y exp %0d got %0d", e.new_a_y, $signed(m_axis_tdata[47:24]));
                    fail_count++;
                end
                if (m_axis_tdata[71:48] !== e.new_b_x) begin
                    $error("new_b_x exp %0d got %0d", e.new_b_x, $signed(m_axis_tdata[71:48]));
                    fail_count++;
                end
                if (m_axis_tdata[95:72] !== e.new_b_y) begin
                    $error("new_b_y exp %0d got %0d", e.new_b_y, $signed(m_axis_tdata[95:72]));
                    fail_count++;
                end
                if (m_axis_tuser[0] !== e.coincident) begin
                    $error("coincident exp %0d got %0d", e.coincident, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_reset();
        i_rst_n = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
    endtask

    // Field extremes, pinning, every bounce setting, coincidence and saturation
    task automatic test_directed();
        send_stick(make_stick(100, 200, 100, 200, 0, 0, 4096, 0));
        send_stick(make_stick(CMIN, CMIN, CMIN, CMIN, 0, 0, 0, 3));
        send_stick(make_stick(CMIN, CMIN, CMAX, CMAX, 0, 0, CMAX, 0));
        send_stick(make_stick(CMIN, CMIN, CMAX, CMAX, 0, 0, 0, 0));
        send_stick(make_stick(CMAX, 0, CMIN, 0, 0, 0, CMAX, 0));
        send_stick(make_stick(0, 0, 1, 0, 0, 0, CMAX, 0));
        send_stick(make_stick(0, 0, 0, -1, 1, 0, CMAX, 1));
        send_stick(make_stick(0, 0, 4096, 4096, 0, 1, 0, 0));
        send_stick(make_stick(-5000, 300, 7000, -900, 1, 1, 100, 0));
        send_stick(make_stick(0, 0, 3 * 4096, 4 * 4096, 0, 0, 5 * 4096, 0));
        for (int b = 0; b < 16; b++)
            send_stick(make_stick(-4096, 8192, 40960, -12288, 0, 0, 20480, b));
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++) send_stick(random_stick());
    endtask

    // Hold the sender until every pending result has come back
    task automatic test_drain_pause();
        wait (expected_moves.size() == 0);
        @(negedge i_clk);
    endtask

    initial begin
        test_reset();
        idle_on = 1'b1;
        test_directed();
        test_random(500);
        test_drain_pause();
        test_random(550);
        idle_on = 1'b0;
        test_random(250);
        wait (expected_moves.size() == 0);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("** distance_constraint_relax: PASSED **");
        end else begin
            $display("** distance_constraint_relax: FAILED **");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("** distance_constraint_relax: FAILED **");
        $finish;
    end

endmodule
